/* rtl/core/i2w_pkg.sv */
package i2w_pkg;

  localparam int VALUE_W = 31;
  localparam int WORD_W  = 5;
  localparam int DIG_W   = 4;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = DIGITS * DIG_W;
  localparam int CNT_W   = $clog2(VALUE_W + 1);
  localparam int GROUPS  = 4;
  localparam int GSLOTS  = 5;
  localparam int SLOTS   = GROUPS * GSLOTS + 1;
  localparam int SLOT_W  = $clog2(SLOTS);

  localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] TOK_TEN       = 5'd10;
  localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
  localparam logic [WORD_W-1:0] TOK_THOUSAND  = 5'd29;
  localparam logic [WORD_W-1:0] TOK_MILLION   = 5'd30;
  localparam logic [WORD_W-1:0] TOK_BILLION   = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic build;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic slots_one;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/i2w_ctrl.sv */
module i2w_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2w_pkg::stat_t stat,
  output i2w_pkg::cmd_t  cmd,
  output i2w_pkg::state_t state
);

  i2w_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2w_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      i2w_pkg::ST_IDLE: begin
        if (in_valid) state_next = i2w_pkg::ST_CONV;
      end
      i2w_pkg::ST_CONV: begin
        if (stat.conv_done) state_next = i2w_pkg::ST_EMIT;
      end
      i2w_pkg::ST_EMIT: begin
        if (stat.out_free && stat.slots_one) state_next = i2w_pkg::ST_IDLE;
      end
      default: state_next = i2w_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      i2w_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      i2w_pkg::ST_CONV: begin
        cmd.shift = !stat.conv_done;
        cmd.build = stat.conv_done;
      end
      i2w_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/i2w_dp.sv */
module i2w_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [i2w_pkg::VALUE_W-1:0]  value,
  input  i2w_pkg::cmd_t                cmd,
  output i2w_pkg::stat_t               stat,
  output logic [i2w_pkg::WORD_W-1:0]   word,
  output logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready
);

  logic [i2w_pkg::VALUE_W-1:0] bin;
  logic [i2w_pkg::BCD_W-1:0]   bcd;
  logic [i2w_pkg::BCD_W-1:0]   adj;
  logic [i2w_pkg::CNT_W-1:0]   cnt;
  logic [i2w_pkg::SLOTS-1:0]   mask;
  logic [i2w_pkg::SLOTS-1:0]   slot_val;
  logic [i2w_pkg::WORD_W-1:0]  slot_tok [i2w_pkg::SLOTS];
  logic [i2w_pkg::SLOT_W-1:0]  sel;
  logic [i2w_pkg::DIG_W-1:0]   dg [i2w_pkg::GROUPS*3];

  // add-3 correction per digit before each shift
  always_comb begin
    for (int i = 0; i < i2w_pkg::DIGITS; i++) begin
      if (bcd[i*i2w_pkg::DIG_W +: i2w_pkg::DIG_W] >= 4'd5) begin
        adj[i*i2w_pkg::DIG_W +: i2w_pkg::DIG_W] =
          bcd[i*i2w_pkg::DIG_W +: i2w_pkg::DIG_W] + 4'd3;
      end else begin
        adj[i*i2w_pkg::DIG_W +: i2w_pkg::DIG_W] =
          bcd[i*i2w_pkg::DIG_W +: i2w_pkg::DIG_W];
      end
    end
  end

  // digit view padded to four full groups
  always_comb begin
    for (int i = 0; i < i2w_pkg::GROUPS*3; i++) begin
      if (i < i2w_pkg::DIGITS) begin
        dg[i] = bcd[i*i2w_pkg::DIG_W +: i2w_pkg::DIG_W];
      end else begin
        dg[i] = '0;
      end
    end
  end

  // per-slot tokens: hundreds digit, hundred, tens or teen, ones, scale
  always_comb begin
    logic [i2w_pkg::DIG_W-1:0] h, t, o;
    logic [i2w_pkg::WORD_W-1:0] sc;
    for (int g = 0; g < i2w_pkg::GROUPS; g++) begin
      o = dg[(i2w_pkg::GROUPS-1-g)*3];
      t = dg[(i2w_pkg::GROUPS-1-g)*3+1];
      h = dg[(i2w_pkg::GROUPS-1-g)*3+2];
      case (g)
        0:       sc = i2w_pkg::TOK_BILLION;
        1:       sc = i2w_pkg::TOK_MILLION;
        default: sc = i2w_pkg::TOK_THOUSAND;
      endcase
      slot_tok[g*i2w_pkg::GSLOTS]   = i2w_pkg::WORD_W'(h);
      slot_val[g*i2w_pkg::GSLOTS]   = (h != '0);
      slot_tok[g*i2w_pkg::GSLOTS+1] = i2w_pkg::TOK_HUNDRED;
      slot_val[g*i2w_pkg::GSLOTS+1] = (h != '0);
      if (t == 4'd1) begin
        slot_tok[g*i2w_pkg::GSLOTS+2] = i2w_pkg::TOK_TEN + i2w_pkg::WORD_W'(o);
        slot_val[g*i2w_pkg::GSLOTS+2] = 1'b1;
      end else begin
        slot_tok[g*i2w_pkg::GSLOTS+2] = i2w_pkg::TOK_TENS_BASE + i2w_pkg::WORD_W'(t);
        slot_val[g*i2w_pkg::GSLOTS+2] = (t != '0);
      end
      slot_tok[g*i2w_pkg::GSLOTS+3] = i2w_pkg::WORD_W'(o);
      slot_val[g*i2w_pkg::GSLOTS+3] = (t != 4'd1) && (o != '0);
      slot_tok[g*i2w_pkg::GSLOTS+4] = sc;
      slot_val[g*i2w_pkg::GSLOTS+4] =
        (g < i2w_pkg::GROUPS-1) && ((h != '0) || (t != '0) || (o != '0));
    end
    slot_tok[i2w_pkg::SLOTS-1] = i2w_pkg::TOK_ZERO;
    slot_val[i2w_pkg::SLOTS-1] = (bcd == '0);
  end

  // lowest pending slot
  always_comb begin
    logic found;
    found = 1'b0;
    sel   = '0;
    for (int s = 0; s < i2w_pkg::SLOTS; s++) begin
      if (mask[s] && !found) begin
        sel   = i2w_pkg::SLOT_W'(s);
        found = 1'b1;
      end
    end
  end

  assign stat.conv_done = (cnt == '0);
  assign stat.slots_one = ((mask & (mask - 1'b1)) == '0);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value;
      bcd <= '0;
      cnt <= i2w_pkg::CNT_W'(i2w_pkg::VALUE_W);
    end else if (cmd.shift) begin
      bin <= {bin[i2w_pkg::VALUE_W-2:0], 1'b0};
      bcd <= {adj[i2w_pkg::BCD_W-2:0], bin[i2w_pkg::VALUE_W-1]};
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      mask <= slot_val;
    end else if (cmd.emit) begin
      mask[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      word <= slot_tok[sel];
      last <= stat.slots_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/integer_to_word_tokens_top.sv */
// channel   | signals                         | direction
// ----------+---------------------------------+----------
// input     | value, in_valid, in_ready       | in
// output    | word, last, out_valid, out_ready| out
//
// each transaction in yields n = 1..16 word tokens out
// bit-serial binary to decimal conversion shifts in all 31 value bits
// tokens leave one per cycle through an output register, held on stall
// a new transaction is taken once the previous tokens are all registered
// synchronous reset returns the controller to idle and drops out_valid
module integer_to_word_tokens_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [i2w_pkg::VALUE_W-1:0] value,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic [i2w_pkg::WORD_W-1:0]  word,
  output logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready
);

  i2w_pkg::cmd_t   cmd;
  i2w_pkg::stat_t  stat;
  i2w_pkg::state_t state;

  i2w_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  i2w_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .word      (word),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("token overwrites pending output");

  a_build_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.build |=> (state == i2w_pkg::ST_EMIT))
    else $error("no emit phase after conversion");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.slots_one) |=> (state == i2w_pkg::ST_IDLE))
    else $error("emit phase overran final token");

endmodule
